@@ hdl/apcl_pkg.sv @@
// ----------------------------------------------------------------------------
// apcl_pkg: shared types and constants for the pointer click layer control
// Holds the item classification, the one-hot mode encoding, the queue entry
// layout and the configuration register bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package apcl_pkg;

  // Number of mouse buttons that map onto the button mask.
  localparam int NUM_BUTTONS = 3;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] CLICKABLE_TIMEOUT_RST = 16'd800;
  localparam logic [14:0] MOVE_THRESHOLD_RST    = 15'd0;
  localparam logic [15:0] WAITING_TIMEOUT_RST   = 16'd50;
  localparam logic [14:0] SUM_MAX               = 15'h7FFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CLICKABLE_TIMEOUT = 2'd0,
    REG_MOVE_THRESHOLD    = 2'd1,
    REG_WAITING_TIMEOUT   = 2'd2
  } reg_index_t;

  // What the front decided an item is.
  typedef enum logic [2:0] {
    KIND_MOVE        = 3'd0,
    KIND_STILL       = 3'd1,
    KIND_BTN_PRESS   = 3'd2,
    KIND_BTN_RELEASE = 3'd3,
    KIND_KEY_OFF     = 3'd4,
    KIND_KEY_NONE    = 3'd5
  } kind_t;

  // Controller mode, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_WAITING   = 4'b0010,
    MODE_CLICKABLE = 4'b0100,
    MODE_CLICKING  = 4'b1000
  } mode_t;

  // Mode codes as reported on the result channel.
  localparam logic [1:0] MODE_CODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_CODE_WAITING   = 2'd1;
  localparam logic [1:0] MODE_CODE_CLICKABLE = 2'd2;
  localparam logic [1:0] MODE_CODE_CLICKING  = 2'd3;

  typedef struct packed {
    kind_t              kind;
    logic [8:0]         motion;      // |dx| + |dy|
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic [2:0]         button_bit;  // one-hot button, zero when out of range
    logic [15:0]        now;
  } item_t;

  typedef struct packed {
    logic [15:0] clickable_timeout;
    logic [14:0] move_threshold;
    logic [15:0] waiting_timeout;
  } cfg_t;

  typedef struct packed {
    logic              layer_enabled;
    logic [1:0]        mode;
    logic [2:0]        button_mask;
    logic              send_buttons;
    logic signed [7:0] out_x;
    logic signed [7:0] out_y;
  } result_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      MODE_IDLE:      c = MODE_CODE_IDLE;
      MODE_WAITING:   c = MODE_CODE_WAITING;
      MODE_CLICKABLE: c = MODE_CODE_CLICKABLE;
      MODE_CLICKING:  c = MODE_CODE_CLICKING;
      default:        c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/apcl_front.sv @@
// ----------------------------------------------------------------------------
// apcl_front: item intake and classification
// Registers each accepted item together with its kind, its motion magnitude
// and its button bit, and hands it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module apcl_front
  import apcl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic              action,
  input  wire logic signed [7:0] delta_x,
  input  wire logic signed [7:0] delta_y,
  input  wire logic              key_is_button,
  input  wire logic [1:0]        button_index,
  input  wire logic              key_pressed,
  input  wire logic [15:0]       now_ms,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output item_t                  push_item
);

  logic  stage_valid;
  item_t stage;
  item_t classified;
  logic  accept;
  logic [7:0] abs_x;
  logic [7:0] abs_y;

  always_comb begin
    abs_x = delta_x[7] ? 8'(-delta_x) : 8'(delta_x);
    abs_y = delta_y[7] ? 8'(-delta_y) : 8'(delta_y);
    classified.motion = {1'b0, abs_x} + {1'b0, abs_y};
    classified.now    = now_ms;
    classified.button_bit = 3'd0;
    if (button_index != 2'd3 && 32'(button_index) < NUM_BUTTONS) begin
      classified.button_bit = 3'd1 << button_index;
    end
    if (!action) begin
      classified.dx   = delta_x;
      classified.dy   = delta_y;
      classified.kind = (delta_x != 8'sd0 || delta_y != 8'sd0) ? KIND_MOVE : KIND_STILL;
    end else begin
      classified.dx = 8'sd0;
      classified.dy = 8'sd0;
      if (key_is_button) begin
        classified.kind = key_pressed ? KIND_BTN_PRESS : KIND_BTN_RELEASE;
      end else begin
        classified.kind = key_pressed ? KIND_KEY_OFF : KIND_KEY_NONE;
      end
    end
  end

  assign item_stall = stage_valid && !push_ready;
  assign accept     = item_valid && !item_stall;
  assign push_valid = stage_valid;
  assign push_item  = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= classified;
    end
  end

endmodule

`default_nettype wire

@@ hdl/apcl_queue.sv @@
// ----------------------------------------------------------------------------
// apcl_queue: short FIFO between front and back
// Circular buffer of classified items so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module apcl_queue
  import apcl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/apcl_back.sv @@
// ----------------------------------------------------------------------------
// apcl_back: mode machine and result register
// Applies each classified item to the controller state and registers the
// result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module apcl_back
  import apcl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire item_t pop_item,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] mark_time;
  logic [15:0] mark_time_next;
  logic [14:0] motion_sum;
  logic [14:0] motion_sum_next;
  logic [2:0]  buttons_held;
  logic [2:0]  buttons_held_next;
  logic        layer_flag;
  logic        layer_flag_next;
  logic        send;
  logic [15:0] elapsed;
  logic [15:0] sum_wide;
  logic [14:0] sum_sat;
  logic        do_pop;

  assign pop_ready = !result_valid || !result_stall;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    mode_next         = mode;
    mark_time_next    = mark_time;
    motion_sum_next   = motion_sum;
    buttons_held_next = buttons_held;
    layer_flag_next   = layer_flag;
    send              = 1'b0;
    elapsed           = pop_item.now - mark_time;
    sum_wide          = {1'b0, motion_sum} + {7'd0, pop_item.motion};
    sum_sat           = sum_wide[15] ? SUM_MAX : sum_wide[14:0];

    case (pop_item.kind)
      KIND_BTN_PRESS: begin
        buttons_held_next = buttons_held | pop_item.button_bit;
        mode_next         = MODE_CLICKING;
        send              = 1'b1;
      end
      KIND_BTN_RELEASE: begin
        buttons_held_next = buttons_held & ~pop_item.button_bit;
        layer_flag_next   = 1'b1;
        mark_time_next    = pop_item.now;
        mode_next         = MODE_CLICKABLE;
        send              = 1'b1;
      end
      KIND_KEY_OFF: begin
        mode_next       = MODE_IDLE;
        layer_flag_next = 1'b0;
      end
      KIND_MOVE: begin
        case (mode)
          MODE_CLICKABLE: begin
            mark_time_next = pop_item.now;
          end
          MODE_WAITING: begin
            // Reaching the threshold turns the layer on and restarts the sum.
            if (sum_sat >= cfg.move_threshold) begin
              motion_sum_next = '0;
              layer_flag_next = 1'b1;
              mark_time_next  = pop_item.now;
              mode_next       = MODE_CLICKABLE;
            end else begin
              motion_sum_next = sum_sat;
            end
          end
          MODE_IDLE: begin
            mark_time_next  = pop_item.now;
            mode_next       = MODE_WAITING;
            motion_sum_next = '0;
          end
          default: begin
          end
        endcase
      end
      KIND_STILL: begin
        case (mode)
          MODE_CLICKABLE: begin
            if (elapsed > cfg.clickable_timeout) begin
              mode_next       = MODE_IDLE;
              layer_flag_next = 1'b0;
            end
          end
          MODE_WAITING: begin
            if (elapsed > cfg.waiting_timeout) begin
              motion_sum_next = '0;
              mode_next       = MODE_IDLE;
            end
          end
          MODE_IDLE: begin
            motion_sum_next = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      mark_time    <= '0;
      motion_sum   <= '0;
      buttons_held <= '0;
      layer_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (do_pop) begin
        mode         <= mode_next;
        mark_time    <= mark_time_next;
        motion_sum   <= motion_sum_next;
        buttons_held <= buttons_held_next;
        layer_flag   <= layer_flag_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      result.layer_enabled <= layer_flag_next;
      result.mode          <= mode_code(mode_next);
      result.button_mask   <= buttons_held_next;
      result.send_buttons  <= send;
      result.out_x         <= pop_item.dx;
      result.out_y         <= pop_item.dy;
    end
  end

endmodule

`default_nettype wire

@@ hdl/auto_pointer_click_layer_control.sv @@
// ----------------------------------------------------------------------------
// auto_pointer_click_layer_control: automatic pointer click layer controller
// Turns a pointer click layer on after enough motion or a button release, off
// after idle time or a non-button key press, and tracks the mouse button mask.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is either a pointer report (action low, delta_x/delta_y) or
// a key event (action high, key_is_button, button_index, key_pressed), and
// carries a wrapping millisecond stamp in now_ms. An item is taken on a clock
// edge where item_valid is high and item_stall is low. Every item yields
// exactly one result item, in order, taken where result_valid is high and
// result_stall is low.
// The path has three register stages: the front register that classifies the
// item, the queue, and the result register in the back. An accepted item is
// registered in the front register, then in a queue entry, then in the result
// register. While result_stall is low a new item can be accepted on every
// cycle, so the sustained rate is one item per clock.
// The mode update is a single compare-and-add step in the back.
// When the receiver stalls, the result holds steady, the queue fills, and
// item_stall rises once the front register cannot drain into it.
// Configuration registers are written over cfg_valid/cfg_ready/cfg_index/
// cfg_data; cfg_ready is always high. Writes are meant for an idle block.
// A synchronous reset on rst empties the pipeline, sets the mode to idle with
// the layer off and the button mask clear, and restores the register defaults
// (clickable timeout 800 ms, threshold 0, waiting timeout 50 ms).
// ----------------------------------------------------------------------------
`default_nettype none

module auto_pointer_click_layer_control
  import apcl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Input item channel
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic              action,
  input  wire logic signed [7:0] delta_x,
  input  wire logic signed [7:0] delta_y,
  input  wire logic              key_is_button,
  input  wire logic [1:0]        button_index,
  input  wire logic              key_pressed,
  input  wire logic [15:0]       now_ms,
  // Result item channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic                   layer_enabled,
  output logic [1:0]             mode,
  output logic [2:0]             button_mask,
  output logic                   send_buttons,
  output logic signed [7:0]      out_x,
  output logic signed [7:0]      out_y,
  // Configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  cfg_t    cfg;
  item_t   push_item;
  item_t   pop_item;
  logic    push_valid;
  logic    push_ready;
  logic    pop_valid;
  logic    pop_ready;
  result_t result;

  // Configuration registers; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clickable_timeout <= CLICKABLE_TIMEOUT_RST;
      cfg.move_threshold    <= MOVE_THRESHOLD_RST;
      cfg.waiting_timeout   <= WAITING_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_CLICKABLE_TIMEOUT: cfg.clickable_timeout <= cfg_data;
        REG_MOVE_THRESHOLD:    cfg.move_threshold    <= cfg_data[14:0];
        REG_WAITING_TIMEOUT:   cfg.waiting_timeout   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: intake and classification.
  apcl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .key_is_button (key_is_button),
    .button_index  (button_index),
    .key_pressed   (key_pressed),
    .now_ms        (now_ms),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  // Queue that decouples the front from the back.
  apcl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: mode machine and result register.
  apcl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign layer_enabled = result.layer_enabled;
  assign mode          = result.mode;
  assign button_mask   = result.button_mask;
  assign send_buttons  = result.send_buttons;
  assign out_x         = result.out_x;
  assign out_y         = result.out_y;

endmodule

`default_nettype wire

@@ hdl/apcl_checker.sv @@
// ----------------------------------------------------------------------------
// apcl_checker: port-level checks for the click layer controller
// Watches the result channel for consistency of mode, layer and buttons.
// ----------------------------------------------------------------------------
`default_nettype none

module apcl_checker
  import apcl_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic              layer_enabled,
  input wire logic [1:0]        mode,
  input wire logic [2:0]        button_mask,
  input wire logic              send_buttons,
  input wire logic signed [7:0] out_x,
  input wire logic signed [7:0] out_y
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(layer_enabled)
      && $stable(mode) && $stable(button_mask) && $stable(send_buttons)
      && $stable(out_x) && $stable(out_y))
    else $error("stalled result changed");

  // The layer is never on in idle or waiting mode.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (mode == MODE_CODE_IDLE || mode == MODE_CODE_WAITING)
      |-> !layer_enabled)
    else $error("layer on outside clickable or clicking mode");

  // Clickable mode always has the layer on.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && mode == MODE_CODE_CLICKABLE |-> layer_enabled)
    else $error("clickable mode with layer off");

  // A button report only follows a button key, which leaves the machine
  // clickable or clicking and carries no motion.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && send_buttons |-> (mode == MODE_CODE_CLICKABLE
      || mode == MODE_CODE_CLICKING) && out_x == 8'sd0 && out_y == 8'sd0)
    else $error("button report with wrong mode or motion");

  // No result on the first edge after reset is released.
  assert property (@(posedge clk)
    $past(rst) && !rst |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind auto_pointer_click_layer_control apcl_checker u_apcl_checker (.*);

`default_nettype wire
